// ===== rtl/core/regex_pattern_tokenizer_assert.svh =====
// Assertion macros used by the tokenizer result queue.
// Expects signals clk and rst in the scope of use.
`ifndef REGEX_PATTERN_TOKENIZER_ASSERT_SVH
`define REGEX_PATTERN_TOKENIZER_ASSERT_SVH

// same-cycle implication
`define RPT_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rpt assertion failed");

// next-cycle implication
`define RPT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rpt assertion failed");

`endif

// ===== rtl/core/rpt_pkg.sv =====
// Package for the regex pattern tokenizer: character codes, token kinds,
// scan modes, result record and queue sizing. No dependencies.
package rpt_pkg;

  localparam int MAX_PATTERN_DEFAULT = 4096;

  localparam int CP_W       = 21;
  localparam int TOK_START_W = 12;
  localparam int TOK_LEN_W   = 13;

  localparam int QUEUE_DEPTH = 4;
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);

  localparam logic [CP_W-1:0] CP_PLUS     = CP_W'(8'h2B);
  localparam logic [CP_W-1:0] CP_STAR     = CP_W'(8'h2A);
  localparam logic [CP_W-1:0] CP_QUESTION = CP_W'(8'h3F);
  localparam logic [CP_W-1:0] CP_CARET    = CP_W'(8'h5E);
  localparam logic [CP_W-1:0] CP_DOLLAR   = CP_W'(8'h24);
  localparam logic [CP_W-1:0] CP_DOT      = CP_W'(8'h2E);
  localparam logic [CP_W-1:0] CP_PIPE     = CP_W'(8'h7C);
  localparam logic [CP_W-1:0] CP_LPAREN   = CP_W'(8'h28);
  localparam logic [CP_W-1:0] CP_RPAREN   = CP_W'(8'h29);
  localparam logic [CP_W-1:0] CP_LBRACKET = CP_W'(8'h5B);
  localparam logic [CP_W-1:0] CP_RBRACKET = CP_W'(8'h5D);
  localparam logic [CP_W-1:0] CP_LBRACE   = CP_W'(8'h7B);
  localparam logic [CP_W-1:0] CP_RBRACE   = CP_W'(8'h7D);
  localparam logic [CP_W-1:0] CP_BSLASH   = CP_W'(8'h5C);
  localparam logic [CP_W-1:0] CP_DIGIT0   = CP_W'(8'h30);
  localparam logic [CP_W-1:0] CP_DIGIT9   = CP_W'(8'h39);
  localparam logic [CP_W-1:0] CP_LOW_S    = CP_W'(8'h73);
  localparam logic [CP_W-1:0] CP_UP_S     = CP_W'(8'h53);
  localparam logic [CP_W-1:0] CP_LOW_W    = CP_W'(8'h77);
  localparam logic [CP_W-1:0] CP_UP_W     = CP_W'(8'h57);
  localparam logic [CP_W-1:0] CP_LOW_D    = CP_W'(8'h64);
  localparam logic [CP_W-1:0] CP_UP_D     = CP_W'(8'h44);

  typedef enum logic [3:0] {
    KIND_WORD     = 4'd0,
    KIND_PLUS     = 4'd1,
    KIND_STAR     = 4'd2,
    KIND_QUESTION = 4'd3,
    KIND_CARET    = 4'd4,
    KIND_DOLLAR   = 4'd5,
    KIND_DOT      = 4'd6,
    KIND_PIPE     = 4'd7,
    KIND_LPAREN   = 4'd8,
    KIND_RPAREN   = 4'd9,
    KIND_SET      = 4'd10,
    KIND_REPEAT   = 4'd11,
    KIND_BACKREF  = 4'd12,
    KIND_CLASS    = 4'd13
  } token_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_UNCLOSED = 2'd1,
    ERR_TOO_LONG = 2'd2
  } error_code_t;

  typedef enum logic [2:0] {
    MODE_NORMAL,
    MODE_BSLASH,
    MODE_LBRACKET,
    MODE_SET,
    MODE_REP,
    MODE_DRAIN
  } scan_mode_t;

  typedef struct packed {
    logic                   pattern_end;
    logic                   run_last;
    error_code_t            error_code;
    logic [TOK_LEN_W-1:0]   token_length;
    logic [TOK_START_W-1:0] token_start;
    token_kind_t            token_kind;
  } result_t;

  // results produced by one accepted character, in order
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } step_push_t;

  function automatic token_kind_t single_kind(logic [CP_W-1:0] cp);
    token_kind_t k;
    case (cp)
      CP_PLUS:     k = KIND_PLUS;
      CP_STAR:     k = KIND_STAR;
      CP_QUESTION: k = KIND_QUESTION;
      CP_CARET:    k = KIND_CARET;
      CP_DOLLAR:   k = KIND_DOLLAR;
      CP_DOT:      k = KIND_DOT;
      CP_PIPE:     k = KIND_PIPE;
      CP_LPAREN:   k = KIND_LPAREN;
      CP_RPAREN:   k = KIND_RPAREN;
      default:     k = KIND_WORD;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/core/rpt_step.sv =====
// Per-character scan step: mode register, word and span trackers, and the
// combinational decode that yields up to two results. Uses rpt_pkg.
module rpt_step import rpt_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [CP_W-1:0] code_point,
  input  logic            final_char,
  output step_push_t      push
);

  localparam int POS_W = $clog2(MAX_PATTERN + 1);
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_PATTERN);

  scan_mode_t       scan_mode, scan_mode_next;
  logic             word_pending, word_pending_next;
  logic [POS_W-1:0] word_first, word_first_next;
  logic [POS_W-1:0] word_count, word_count_next;
  logic [POS_W-1:0] char_position, char_position_next;
  logic [POS_W-1:0] span_first, span_first_next;
  logic [POS_W-1:0] span_count, span_count_next;
  logic [POS_W-1:0] escape_position, escape_position_next;

  logic        too_long, is_single, is_open, is_digit, is_class, is_neg, is_close;
  token_kind_t sk, span_kind;

  // decode results
  logic             do_flush, lit_add;
  logic [POS_W-1:0] lit_start;
  logic [1:0]       lit_cnt;
  logic             tok_valid;
  token_kind_t      tok_kind;
  logic [POS_W-1:0] tok_start, tok_len;
  error_code_t      tok_err;

  assign too_long  = char_position >= POS_LIMIT;
  assign sk        = single_kind(code_point);
  assign is_single = sk != KIND_WORD;
  assign is_open   = code_point == CP_LBRACKET || code_point == CP_LBRACE;
  assign is_digit  = code_point inside {[CP_DIGIT0:CP_DIGIT9]};
  assign is_class  = code_point inside {CP_LOW_S, CP_UP_S, CP_LOW_W, CP_UP_W,
                                        CP_LOW_D, CP_UP_D};
  assign is_neg    = scan_mode == MODE_LBRACKET && code_point == CP_CARET;
  assign is_close  = (scan_mode == MODE_REP) ? code_point == CP_RBRACE
                                             : code_point == CP_RBRACKET;
  assign span_kind = (scan_mode == MODE_REP) ? KIND_REPEAT : KIND_SET;

  // event decode for the ordinary path (not draining, not over length)
  always_comb begin
    do_flush  = 1'b0;
    lit_add   = 1'b0;
    lit_start = char_position;
    lit_cnt   = 2'd1;
    tok_valid = 1'b0;
    tok_kind  = KIND_WORD;
    tok_start = char_position;
    tok_len   = '0;
    tok_err   = ERR_NONE;
    case (scan_mode)
      MODE_NORMAL: begin
        if (is_single) begin
          do_flush  = 1'b1;
          tok_valid = 1'b1;
          tok_kind  = sk;
          tok_len   = POS_W'(1);
        end else if (is_open) begin
          do_flush  = 1'b1;
          tok_valid = final_char;
          tok_kind  = (code_point == CP_LBRACKET) ? KIND_SET : KIND_REPEAT;
          tok_err   = ERR_UNCLOSED;
        end else if (code_point == CP_BSLASH) begin
          lit_add = final_char;
        end else begin
          lit_add = 1'b1;
        end
      end
      MODE_BSLASH: begin
        if (is_digit || is_class) begin
          do_flush  = 1'b1;
          tok_valid = 1'b1;
          tok_kind  = is_digit ? KIND_BACKREF : KIND_CLASS;
          tok_start = escape_position;
          tok_len   = POS_W'(2);
        end else begin
          lit_add   = 1'b1;
          lit_start = escape_position;
          lit_cnt   = 2'd2;
        end
      end
      MODE_LBRACKET, MODE_SET, MODE_REP: begin
        if (is_neg) begin
          tok_valid = final_char;
          tok_kind  = KIND_SET;
          tok_err   = ERR_UNCLOSED;
        end else if (is_close) begin
          tok_valid = 1'b1;
          tok_kind  = span_kind;
          tok_start = span_first;
          tok_len   = span_count + POS_W'(1);
        end else begin
          tok_valid = final_char;
          tok_kind  = span_kind;
          tok_start = span_first;
          tok_err   = ERR_UNCLOSED;
        end
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    scan_mode_next       = scan_mode;
    word_pending_next    = word_pending;
    word_first_next      = word_first;
    word_count_next      = word_count;
    char_position_next   = char_position;
    span_first_next      = span_first;
    span_count_next      = span_count;
    escape_position_next = escape_position;
    if (accept && scan_mode != MODE_DRAIN && too_long) begin
      word_pending_next = 1'b0;
      word_count_next   = '0;
      scan_mode_next    = MODE_DRAIN;
    end else if (accept && scan_mode != MODE_DRAIN) begin
      char_position_next = char_position + POS_W'(1);
      if (do_flush) begin
        word_pending_next = 1'b0;
        word_count_next   = '0;
      end
      if (lit_add) begin
        word_pending_next = 1'b1;
        if (!word_pending) begin
          word_first_next = lit_start;
          word_count_next = POS_W'(lit_cnt);
        end else begin
          word_count_next = word_count + POS_W'(lit_cnt);
        end
      end
      case (scan_mode)
        MODE_NORMAL: begin
          if (!is_single && is_open) begin
            span_first_next = char_position;
            span_count_next = POS_W'(1);
            scan_mode_next  = (code_point == CP_LBRACKET) ? MODE_LBRACKET : MODE_REP;
          end else if (!is_single && code_point == CP_BSLASH) begin
            escape_position_next = char_position;
            if (!final_char) begin
              scan_mode_next = MODE_BSLASH;
            end
          end
        end
        MODE_BSLASH: begin
          scan_mode_next = MODE_NORMAL;
        end
        MODE_LBRACKET, MODE_SET, MODE_REP: begin
          if (is_neg) begin
            span_first_next = char_position;
            span_count_next = POS_W'(1);
            scan_mode_next  = MODE_SET;
          end else begin
            span_count_next = span_count + POS_W'(1);
            if (is_close) begin
              scan_mode_next = MODE_NORMAL;
            end else begin
              scan_mode_next = (scan_mode == MODE_REP) ? MODE_REP : MODE_SET;
            end
          end
        end
        default: begin
        end
      endcase
    end
    // end of pattern returns the scanner to its idle state
    if (accept && final_char) begin
      scan_mode_next     = MODE_NORMAL;
      word_pending_next  = 1'b0;
      word_count_next    = '0;
      char_position_next = '0;
    end
  end

  // result outputs
  always_comb begin
    logic             pre, post, post_pend;
    logic [POS_W-1:0] post_first, post_count;
    result_t          word_pre, word_post, tok;
    pre        = word_pending && do_flush;
    post_pend  = lit_add || (word_pending && !do_flush);
    post       = final_char && post_pend;
    post_first = word_pending ? word_first : lit_start;
    post_count = lit_add ? (word_pending ? word_count + POS_W'(lit_cnt) : POS_W'(lit_cnt))
                         : word_count;

    word_pre  = '{pattern_end: 1'b0, run_last: 1'b0, error_code: ERR_NONE,
                  token_length: TOK_LEN_W'(word_count),
                  token_start: TOK_START_W'(word_first), token_kind: KIND_WORD};
    word_post = '{pattern_end: 1'b0, run_last: 1'b0, error_code: ERR_NONE,
                  token_length: TOK_LEN_W'(post_count),
                  token_start: TOK_START_W'(post_first), token_kind: KIND_WORD};
    tok       = '{pattern_end: 1'b0, run_last: 1'b0, error_code: tok_err,
                  token_length: TOK_LEN_W'(tok_len),
                  token_start: TOK_START_W'(tok_start), token_kind: tok_kind};

    push.second = tok;
    if (scan_mode == MODE_DRAIN) begin
      push.count = 2'd0;
      push.first = word_pre;
    end else if (too_long) begin
      push.count = 2'd1;
      push.first = '{pattern_end: 1'b1, run_last: 1'b1, error_code: ERR_TOO_LONG,
                     token_length: '0, token_start: '0, token_kind: KIND_WORD};
    end else begin
      push.count = 2'(pre) + 2'(tok_valid) + 2'(post);
      push.first = pre ? word_pre : (tok_valid ? tok : word_post);
    end
    // last result of this character carries the run and pattern flags;
    // an over-length character always ends the pattern
    if (push.count == 2'd1) begin
      push.first.run_last    = 1'b1;
      push.first.pattern_end = final_char || too_long;
    end
    push.second.run_last    = 1'b1;
    push.second.pattern_end = final_char;
    if (!accept) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode     <= MODE_NORMAL;
      word_pending  <= 1'b0;
      word_count    <= '0;
      char_position <= '0;
    end else begin
      scan_mode     <= scan_mode_next;
      word_pending  <= word_pending_next;
      word_count    <= word_count_next;
      char_position <= char_position_next;
    end
  end

  always_ff @(posedge clk) begin
    word_first      <= word_first_next;
    span_first      <= span_first_next;
    span_count      <= span_count_next;
    escape_position <= escape_position_next;
  end

endmodule

// ===== rtl/core/rpt_outq.sv =====
// Result queue: takes zero, one or two results a cycle, hands out one while m_tready is high.
// Uses rpt_pkg and the assertion macro header.
`include "regex_pattern_tokenizer_assert.svh"

module rpt_outq import rpt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  step_push_t push,
  output logic       in_ready,
  output logic       m_tvalid,
  input  logic       m_tready,
  output result_t    head
);

  result_t            entries [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [Q_PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [Q_CNT_W-1:0] count, count_next;
  logic               pop;

  assign m_tvalid = count != '0;
  assign pop      = m_tvalid && m_tready;
  assign head     = entries[rd_ptr];
  // room for the worst case of two results from the next character
  assign in_ready = count <= Q_CNT_W'(QUEUE_DEPTH - 2);

  assign wr_ptr_next = wr_ptr + Q_PTR_W'(push.count);
  assign rd_ptr_next = rd_ptr + Q_PTR_W'(pop);
  assign count_next  = count + Q_CNT_W'(push.count) - Q_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + Q_PTR_W'(1)] <= push.second;
    end
  end

  `RPT_ASSERT_IMPLY(a_room_for_push, push.count != 2'd0, int'(count) + int'(push.count) <= QUEUE_DEPTH)
  `RPT_ASSERT_IMPLY(a_pair_order, push.count == 2'd2, push.second.run_last && !push.first.run_last)
  `RPT_ASSERT_IMPLY(a_end_is_last, push.count == 2'd1 && push.first.pattern_end, push.first.run_last)
  `RPT_ASSERT_NEXT(a_drain_empty, pop && count == Q_CNT_W'(1) && push.count == 2'd0, count == '0)

endmodule

// ===== rtl/core/regex_pattern_tokenizer.sv =====
// Regex pattern tokenizer, top level: stream ports, scan step, result queue.
// Depends on rpt_pkg, rpt_step and rpt_outq.
//
//  channel | dir | tdata                                         | tuser      | tlast
//  --------+-----+-----------------------------------------------+------------+------------
//  s_*     | in  | code_point[20:0]                              | -          | final_char
//  m_*     | out | kind[3:0] start[15:4] length[28:16] run[29]   | error_code | pattern_end
//
// One character is taken per cycle while s_tready is high; its tokens (zero
// to two) are decided in the same cycle from the scan state and land in a
// four-entry result queue, which hands out one token per cycle while m_tready
// is high. s_tready drops only when the queue holds more than two tokens, as
// when the output side stalls or characters keep yielding two tokens each.
// Synchronous reset clears the scan state and empties the queue.
module regex_pattern_tokenizer import rpt_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [20:0] code_point, [23:21] zero
  input  logic        s_tlast,   // final_char
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [3:0] token_kind, [15:4] token_start,
                                 // [28:16] token_length, [29] run_last, [31:30] zero
  output logic [1:0]  m_tuser,   // error_code
  output logic        m_tlast    // pattern_end
);

  logic       accept;
  step_push_t push;
  result_t    head;

  // input transfer
  assign accept = s_tvalid && s_tready;

  rpt_step #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_step (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .code_point(s_tdata[CP_W-1:0]),
    .final_char(s_tlast),
    .push      (push)
  );

  rpt_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .in_ready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .head    (head)
  );

  // pack the queue head onto the output stream
  assign m_tdata = {2'b00, head.run_last, head.token_length, head.token_start,
                    head.token_kind};
  assign m_tuser = head.error_code;
  assign m_tlast = head.pattern_end;

endmodule
